>>> sv/laser_scan_steer_controller_top_macros.svh
// Assertion macros shared by the RTL of the scan steering controller.
// Bodies compile to nothing when SYNTHESIS is defined.
`ifndef LASER_SCAN_STEER_CONTROLLER_TOP_MACROS_SVH
`define LASER_SCAN_STEER_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// plain property, checked on every clock outside reset
`define LSSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lssc assertion failed");

// overlapping implication
`define LSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lssc implication failed");

// next-cycle implication
`define LSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lssc next-cycle implication failed");

`else

`define LSSC_ASSERT(lbl, clk, rst_n, prop)
`define LSSC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/lssc_pkg.sv
`default_nettype none

package lssc_pkg;

    localparam int BEAM_COUNT    = 360;
    localparam int WEIGHT_COUNT  = 38;
    localparam int SAMPLE_STRIDE = 5;

    localparam int BEAM_W = 9;
    localparam int RANGE_W = 16;
    localparam int WIDX_W = $clog2(WEIGHT_COUNT);
    localparam int SPEED_W = 16;

    localparam int WIN1_END   = 90;
    localparam int WIN2_START = 270;

    // beam / 5 as (beam * 205) >> 10, exact for beam below 1024
    localparam int DIV_MUL = 205;
    localparam int DIV_MUL_W = 8;
    localparam int DIV_SH = 10;
    localparam int QUOT_W = 7;

    // weight index offsets for the two windows
    localparam int WIN1_OFS = 1;
    localparam int WIN2_OFS = 2 + WIN1_END / SAMPLE_STRIDE - WIN2_START / SAMPLE_STRIDE;

    localparam int FRONT_W = 18;
    localparam logic [FRONT_W-1:0] FRONT_MAX = '1;

    localparam int PROD_W = 33;
    localparam int ACC_W = 48;
    localparam int TOT_W = ACC_W + 1;

    localparam logic signed [SPEED_W-1:0] REV_FWD  = -16'sd2048;
    localparam logic signed [SPEED_W-1:0] REV_TURN = 16'sd4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEER_THR   = 3'd0,
        CFG_TURN_RATE   = 3'd1,
        CFG_HIT_THR     = 3'd2,
        CFG_RELEASE_THR = 3'd3,
        CFG_MIN_RANGE   = 3'd4,
        CFG_SUBST_RANGE = 3'd5,
        CFG_HITS_TO_REV = 3'd6,
        CFG_CRUISE      = 3'd7
    } t_cfg_idx;

    localparam logic signed [15:0] WEIGHT_ROM [WEIGHT_COUNT] = '{
        16'sd16246, -16'sd9295, 16'sd5325, 16'sd12617, -16'sd12201, -16'sd7749,
        16'sd19170, -16'sd7327, -16'sd5200, -16'sd9432, -16'sd18279, -16'sd15473,
        -16'sd3897, -16'sd15080, -16'sd6524, 16'sd17002, -16'sd19817, -16'sd10099,
        16'sd9842, -16'sd10221, 16'sd20236, -16'sd10568, -16'sd4756, -16'sd1767,
        -16'sd11250, 16'sd19406, 16'sd15064, 16'sd19033, 16'sd20270, 16'sd16395,
        -16'sd5270, 16'sd7603, -16'sd10928, -16'sd20072, -16'sd18421, 16'sd12091,
        16'sd8689, 16'sd13671
    };

    // bias weight aligned to Q7.24
    localparam logic signed [TOT_W-1:0] BIAS_Q24 = TOT_W'(WEIGHT_ROM[0]) <<< 12;

    typedef struct packed {
        logic [15:0]        steer_threshold;
        logic [14:0]        turn_rate;
        logic [FRONT_W-1:0] hit_threshold;
        logic [FRONT_W-1:0] release_threshold;
        logic [15:0]        min_valid_range;
        logic [15:0]        substitute_range;
        logic [7:0]         hits_to_reverse;
        logic [14:0]        cruise_speed;
    } t_cfg;

    // one classified word as it waits in the queue
    typedef struct packed {
        logic               use_mac;
        logic [WIDX_W-1:0]  widx;
        logic [RANGE_W-1:0] sample;
        logic               front;
        logic               no_return;
        logic [RANGE_W-1:0] range;
        logic               last;
    } t_item;

    typedef struct packed {
        logic not_empty;
        logic pop;
    } t_q_ctl;

endpackage

`default_nettype wire

>>> sv/lssc_front.sv
`default_nettype none

module lssc_front import lssc_pkg::*; (
    input  wire logic [BEAM_W-1:0]  i_beam_index,
    input  wire logic [RANGE_W-1:0] i_range_sample,
    input  wire logic               i_no_return,
    input  wire logic               i_last_beam,
    input  wire logic [15:0]        i_min_valid_range,
    input  wire logic [15:0]        i_substitute_range,
    output t_item                   o_item
);

    logic [BEAM_W+DIV_MUL_W-1:0] prod;
    logic [QUOT_W-1:0]           quot;
    logic [BEAM_W-1:0]           rem;
    logic                        on_stride;
    logic                        win1;
    logic                        win2;
    logic [QUOT_W:0]             widx_full;

    always_comb begin
        prod = i_beam_index * DIV_MUL_W'(DIV_MUL);
        quot = QUOT_W'(prod >> DIV_SH);
        rem  = i_beam_index - BEAM_W'({quot, 2'b00} + quot);
        on_stride = (i_beam_index < BEAM_W'(BEAM_COUNT)) && (rem == '0);
        win1 = i_beam_index <= BEAM_W'(WIN1_END);
        win2 = i_beam_index >= BEAM_W'(WIN2_START);

        if (win1) begin
            widx_full = {1'b0, quot} + (QUOT_W+1)'(WIN1_OFS);
        end else begin
            widx_full = {1'b0, quot} + (QUOT_W+1)'(WIN2_OFS);
        end

        o_item.use_mac = on_stride && (win1 || win2)
                         && (widx_full < (QUOT_W+1)'(WEIGHT_COUNT));
        o_item.widx = WIDX_W'(widx_full);
        o_item.sample = (i_no_return || (i_range_sample < i_min_valid_range))
                        ? i_substitute_range : i_range_sample;
        o_item.front = (i_beam_index == BEAM_W'(0)) || (i_beam_index == BEAM_W'(1))
                       || (i_beam_index == BEAM_W'(BEAM_COUNT - 1));
        o_item.no_return = i_no_return;
        o_item.range = i_range_sample;
        o_item.last = i_last_beam;
    end

endmodule

`default_nettype wire

>>> sv/lssc_queue.sv
`default_nettype none

`include "laser_scan_steer_controller_top_macros.svh"

module lssc_queue import lssc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_not_empty,
    output t_item      o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full      = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_item      = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

    `LSSC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH))
    `LSSC_ASSERT_NEXT(a_count_track, i_clk, i_rst_n, do_push && !do_pop,
                      r_count == $past(r_count) + 1'b1)
    `LSSC_ASSERT_IMP(a_ptr_gap, i_clk, i_rst_n, r_count == '0, r_wr_ptr == r_rd_ptr)

endmodule

`default_nettype wire

>>> sv/lssc_back.sv
`default_nettype none

`include "laser_scan_steer_controller_top_macros.svh"

module lssc_back import lssc_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire t_item               i_item,
    input  wire logic                i_not_empty,
    output t_q_ctl                   o_q_ctl,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [SPEED_W-1:0] o_forward_speed,
    output logic signed [SPEED_W-1:0] o_turn_speed,
    output logic                     o_reversing
);

    logic adv;
    logic pop;

    // stage A: weight lookup and product
    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_a_prod;
    logic                     r_a_front;
    logic                     r_a_nret;
    logic [RANGE_W-1:0]       r_a_range;
    logic                     r_a_last;

    // stage B: accumulators
    logic signed [ACC_W-1:0]  r_wsum;
    logic [FRONT_W-1:0]       r_front;
    logic signed [ACC_W-1:0]  n_wsum;
    logic [FRONT_W-1:0]       n_front;
    logic [FRONT_W:0]         front_add;

    // stage C: end-of-scan decision
    logic                     r_c_valid;
    logic signed [ACC_W-1:0]  r_c_wsum;
    logic [FRONT_W-1:0]       r_c_front;

    logic [7:0]               r_hit_count;
    logic                     r_rev;
    logic [7:0]               n_hit_count;
    logic                     n_rev;
    logic signed [SPEED_W-1:0] n_fwd;
    logic signed [SPEED_W-1:0] n_turn;
    logic signed [TOT_W-1:0]  total;
    logic signed [TOT_W-1:0]  thr;
    logic                     hit;

    logic signed [PROD_W-1:0] prod;

    assign adv = !o_valid || i_ready;
    assign pop = adv && i_not_empty;
    assign o_q_ctl.not_empty = i_not_empty;
    assign o_q_ctl.pop = pop;

    assign prod = $signed({1'b0, i_item.sample}) * WEIGHT_ROM[i_item.widx];

    always_comb begin
        n_wsum = r_wsum + ACC_W'(r_a_prod);
        front_add = {1'b0, r_front} + (FRONT_W+1)'(r_a_range);
        n_front = r_front;
        if (r_a_front) begin
            if (r_a_nret || front_add > (FRONT_W+1)'(FRONT_MAX)) begin
                n_front = FRONT_MAX;
            end else begin
                n_front = FRONT_W'(front_add);
            end
        end
    end

    always_comb begin
        hit = r_c_front < i_cfg.hit_threshold;
        n_hit_count = r_hit_count;
        n_rev = r_rev;
        if (hit) begin
            if (r_hit_count != 8'hFF) begin
                n_hit_count = r_hit_count + 8'd1;
            end
            if (n_hit_count >= i_cfg.hits_to_reverse) begin
                n_rev = 1'b1;
            end
        end else begin
            n_hit_count = '0;
        end

        total = TOT_W'(r_c_wsum) + BIAS_Q24;
        thr = $signed({(TOT_W-28)'(0), i_cfg.steer_threshold, 12'b0});
        n_fwd = $signed({1'b0, i_cfg.cruise_speed});
        n_turn = '0;
        if (n_rev) begin
            if (r_c_front < i_cfg.release_threshold) begin
                n_fwd = REV_FWD;
                n_turn = REV_TURN;
            end else begin
                n_rev = 1'b0;
                n_hit_count = '0;
            end
        end else if (total > thr) begin
            n_turn = -$signed({1'b0, i_cfg.turn_rate});
        end else if (total < -thr) begin
            n_turn = $signed({1'b0, i_cfg.turn_rate});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            o_valid     <= 1'b0;
            r_wsum      <= '0;
            r_front     <= '0;
            r_hit_count <= '0;
            r_rev       <= 1'b0;
        end else if (adv) begin
            r_a_valid <= pop;
            r_c_valid <= r_a_valid && r_a_last;
            o_valid   <= r_c_valid;
            if (r_a_valid) begin
                if (r_a_last) begin
                    r_wsum  <= '0;
                    r_front <= '0;
                end else begin
                    r_wsum  <= n_wsum;
                    r_front <= n_front;
                end
            end
            if (r_c_valid) begin
                r_hit_count <= n_hit_count;
                r_rev       <= n_rev;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_prod  <= i_item.use_mac ? prod : '0;
            r_a_front <= i_item.front;
            r_a_nret  <= i_item.no_return;
            r_a_range <= i_item.range;
            r_a_last  <= i_item.last;
            r_c_wsum  <= n_wsum;
            r_c_front <= n_front;
            if (r_c_valid) begin
                o_forward_speed <= n_fwd;
                o_turn_speed    <= n_turn;
                o_reversing     <= n_rev;
            end
        end
    end

    `LSSC_ASSERT_IMP(a_rev_cmd, i_clk, i_rst_n, o_valid && o_reversing,
                     o_forward_speed == REV_FWD && o_turn_speed == REV_TURN)
    `LSSC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !adv,
                      $stable(r_hit_count) && $stable(r_rev) && $stable(r_wsum))
    `LSSC_ASSERT_IMP(a_rev_flag, i_clk, i_rst_n, o_valid && !adv, o_reversing == r_rev)

endmodule

`default_nettype wire

>>> sv/laser_scan_steer_controller_top.sv
// Laser scan steering controller.
// Input channel (i_valid / o_ready) takes one range word per beam, in beam order,
// with its beam index, a no-return flag and a last-beam flag. Every fifth beam in the
// two side windows is weighted and summed; beams 0, 1 and the final beam form the
// frontal sum. Only the word flagged last produces a result.
// Output channel (o_valid / i_ready) gives forward speed, turn speed and the
// reversing flag once per scan.
// Throughput: one beam per cycle, sustained. A four-entry queue sits between the
// classifier and the multiply-accumulate pipeline, so o_ready only drops once the
// queue has filled behind a stalled output.
// After the last beam is taken, its result passes through the queue, the queue read with
// weight product, the accumulate stage and the decision into the output register.
// While a result waits with i_ready low the result register holds and the back pipeline
// freezes; the front keeps taking words until the queue is full.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data at once;
// write only while the block is idle.
// Reset (synchronous, active low) restores the register defaults and clears the
// sums, hit counter, reversing mode, queue and output valid.
`default_nettype none

module laser_scan_steer_controller_top import lssc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [BEAM_W-1:0]     i_beam_index,
    input  wire logic [RANGE_W-1:0]    i_range_sample,
    input  wire logic                  i_no_return,
    input  wire logic                  i_last_beam,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic signed [SPEED_W-1:0]  o_forward_speed,
    output logic signed [SPEED_W-1:0]  o_turn_speed,
    output logic                       o_reversing,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_item  front_item;
    t_item  q_item;
    t_q_ctl q_ctl;
    logic   q_full;
    logic   q_not_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steer_threshold   <= 16'd3072;
            r_cfg.turn_rate         <= 15'd3891;
            r_cfg.hit_threshold     <= 18'd1720;
            r_cfg.release_threshold <= 18'd4096;
            r_cfg.min_valid_range   <= 16'd614;
            r_cfg.substitute_range  <= 16'd14746;
            r_cfg.hits_to_reverse   <= 8'd3;
            r_cfg.cruise_speed      <= 15'd2458;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEER_THR:   r_cfg.steer_threshold   <= i_cfg_data[15:0];
                CFG_TURN_RATE:   r_cfg.turn_rate         <= i_cfg_data[14:0];
                CFG_HIT_THR:     r_cfg.hit_threshold     <= i_cfg_data[17:0];
                CFG_RELEASE_THR: r_cfg.release_threshold <= i_cfg_data[17:0];
                CFG_MIN_RANGE:   r_cfg.min_valid_range   <= i_cfg_data[15:0];
                CFG_SUBST_RANGE: r_cfg.substitute_range  <= i_cfg_data[15:0];
                CFG_HITS_TO_REV: r_cfg.hits_to_reverse   <= i_cfg_data[7:0];
                CFG_CRUISE:      r_cfg.cruise_speed      <= i_cfg_data[14:0];
                default:         r_cfg.cruise_speed      <= r_cfg.cruise_speed;
            endcase
        end
    end

    assign o_ready = !q_full;

    lssc_front u_front (
        .i_beam_index       (i_beam_index),
        .i_range_sample     (i_range_sample),
        .i_no_return        (i_no_return),
        .i_last_beam        (i_last_beam),
        .i_min_valid_range  (r_cfg.min_valid_range),
        .i_substitute_range (r_cfg.substitute_range),
        .o_item             (front_item)
    );

    lssc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid),
        .i_item      (front_item),
        .o_full      (q_full),
        .i_pop       (q_ctl.pop),
        .o_not_empty (q_not_empty),
        .o_item      (q_item)
    );

    lssc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_item          (q_item),
        .i_not_empty     (q_not_empty),
        .o_q_ctl         (q_ctl),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_forward_speed (o_forward_speed),
        .o_turn_speed    (o_turn_speed),
        .o_reversing     (o_reversing)
    );

endmodule

`default_nettype wire
